>>> hdl/postfix_prefix_stack_evaluator_macros.svh
// Assertion macros for the stack evaluator.
// Used by the controller.
`ifndef POSTFIX_PREFIX_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_PREFIX_STACK_EVALUATOR_MACROS_SVH
`define PPSE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PPSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hdl/ppse_pkg.sv
// Shared types and constants for the stack evaluator.
// No dependencies.
package ppse_pkg;
  localparam logic [7:0] SYM_ZERO  = 8'h30;
  localparam logic [7:0] SYM_NINE  = 8'h39;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_MUL   = 8'h2A;
  localparam logic [7:0] SYM_DIV   = 8'h2F;
  localparam logic [7:0] SYM_DOLR  = 8'h24;
  localparam logic [7:0] SYM_CARET = 8'h5E;

  localparam int OUT_WIDTH = 16;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_MATH      = 3'd3,
    ST_BADSYM    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_READ1, S_READ2, S_EXEC, S_ITER, S_WRITE, S_FINISH, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input transaction
    logic push;      // write digit
    logic rd_top;    // read top entry
    logic rd_below;  // read entry below top
    logic exec;      // start operator
    logic iter;      // one iteration step
    logic wr_res;    // write result, pop one
    logic rd_last;   // read top for result
    logic finish;    // latch result, clear stack
    logic out_take;  // result taken
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic is_last;
    logic full;
    logic lt2;
    logic iter_done;
    logic multi;     // operator needs iterations
  } dp_stat_t;
endpackage

>>> hdl/ppse_if.sv
// Valid/ready channel interfaces for the stack evaluator.
// Depends on nothing.
interface ppse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;
  modport source (output valid, symbol, last, input ready);
  modport sink (input valid, symbol, last, output ready);
endinterface

interface ppse_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;
  logic [2:0]  status;
  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

interface ppse_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> hdl/postfix_prefix_stack_evaluator.sv
// Postfix/prefix expression evaluator, one transaction at a time. Divide and power
// with a non-negative exponent iterate one quotient or exponent bit per cycle. On a
// last item the result is held valid until taken, and no new item is accepted
// before it is taken.
// Reset (rst, synchronous) empties the stack, clears error and prefix_mode.
module postfix_prefix_stack_evaluator import ppse_pkg::*; #(
  parameter int STACK_DEPTH = 32,
  parameter int VALUE_WIDTH = 16
) (
  input logic clk,
  input logic rst,
  ppse_in_if.sink    in_ch,
  ppse_out_if.source out_ch,
  ppse_cfg_if.sink   cfg
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic prefix_mode;
  logic in_ready;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) prefix_mode <= 1'b0;
    else if (cfg.valid) prefix_mode <= cfg.data;
  end

  assign in_ch.ready = in_ready;

  ppse_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .stat(stat)
  );

  ppse_datapath #(.STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_symbol(in_ch.symbol), .in_last(in_ch.last),
    .prefix_mode(prefix_mode),
    .res_value(out_ch.value), .res_status(out_ch.status)
  );
endmodule

>>> hdl/ppse_datapath.sv
// Datapath: operand stack memory, count, error, iterative divide and power.
// Depends on ppse_pkg.
module ppse_datapath import ppse_pkg::*; #(
  parameter int STACK_DEPTH = 32,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [7:0]           in_symbol,
  input  logic                 in_last,
  input  logic                 prefix_mode,
  output logic [OUT_WIDTH-1:0] res_value,
  output logic [2:0]           res_status
);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(VALUE_WIDTH + 1);
  localparam int W = VALUE_WIDTH;

  logic [W-1:0] mem [STACK_DEPTH];
  logic [W-1:0] rdata;
  logic [CW-1:0] count;
  logic [2:0] err;
  logic [7:0] sym;
  logic last;
  op_t op;
  logic [W-1:0] top, below, left, right;
  logic [W-1:0] acc, aux, rem, result;
  logic [IW-1:0] cnt;
  logic neg_q, div_zero;
  logic fresh;
  logic [W-1:0] top_val;

  logic is_digit, is_op;
  always_comb begin
    is_digit = (sym >= SYM_ZERO) && (sym <= SYM_NINE);
    is_op = (sym == SYM_PLUS) || (sym == SYM_MINUS) || (sym == SYM_MUL) ||
            (sym == SYM_DIV) || (sym == SYM_DOLR) || (sym == SYM_CARET);
  end

  logic [AW-1:0] rd_addr, wr_addr;
  logic [CW-1:0] cm1, cm2;
  assign cm1 = count - CW'(1);
  assign cm2 = count - CW'(2);
  always_comb begin
    rd_addr = cmd.rd_top ? cm2[AW-1:0] : cm1[AW-1:0];
    wr_addr = cmd.push ? count[AW-1:0] : cm2[AW-1:0];
  end

  logic [W-1:0] wdata;
  assign wdata = cmd.push ? W'(sym - SYM_ZERO) : result;

  always_ff @(posedge clk) begin
    if (cmd.push && !(count == CW'(STACK_DEPTH))) mem[wr_addr] <= wdata;
    else if (cmd.wr_res) mem[wr_addr] <= wdata;
    rdata <= mem[rd_addr];
  end

  function automatic logic [W-1:0] neg(input logic [W-1:0] v);
    return ~v + W'(1);
  endfunction

  // restoring divide step
  logic [W:0] trial;
  logic [W-1:0] rem_sh;
  assign rem_sh = {rem[W-2:0], acc[W-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, aux};

  logic [2*W-1:0] prod_a, prod_s;
  assign prod_a = acc * aux;
  assign prod_s = aux * aux;

  logic pow_exact;
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      err <= ST_OK;
    end else begin
      if (cmd.push) begin
        if (count == CW'(STACK_DEPTH)) begin
          if (err == ST_OK) err <= ST_OVERFLOW;
        end else count <= count + CW'(1);
      end
      if (cmd.exec && !is_op && !is_digit && err == ST_OK) err <= ST_BADSYM;
      if (cmd.exec && is_op && count < CW'(2) && err == ST_OK) err <= ST_UNDERFLOW;
      if (cmd.wr_res) begin
        count <= cm1;
        if (div_zero && err == ST_OK) err <= ST_MATH;
      end
      if (cmd.finish) begin
        count <= '0;
        err <= ST_OK;
      end
    end
  end

  // right after a write the memory read is stale; take the result register
  assign top_val = fresh ? result : rdata;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym <= in_symbol;
      last <= in_last;
    end
    fresh <= cmd.wr_res;
    if (cmd.rd_top) top <= rdata;
    if (cmd.rd_below) below <= rdata;
    if (cmd.finish) begin
      res_value <= (count == '0) ? '0 : OUT_WIDTH'({{64{top_val[W-1]}}, top_val});
      res_status <= (err == ST_OK && count == '0) ? ST_UNDERFLOW : err;
    end
  end

  // operand fetch: top read during decode, entry below during rd_top
  assign left = prefix_mode ? top : below;
  assign right = prefix_mode ? below : top;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      div_zero <= 1'b0;
      pow_exact <= 1'b0;
      cnt <= IW'(W);
      rem <= '0;
      case (sym)
        SYM_PLUS: begin op <= OP_ADD; result <= left + right; end
        SYM_MINUS: begin op <= OP_SUB; result <= left - right; end
        SYM_MUL: begin op <= OP_MUL; result <= W'(left * right); end
        SYM_DIV: begin
          op <= OP_DIV;
          acc <= left[W-1] ? neg(left) : left;
          aux <= right[W-1] ? neg(right) : right;
          neg_q <= left[W-1] ^ right[W-1];
          div_zero <= (right == '0);
          result <= '0;
        end
        default: begin
          op <= OP_POW;
          acc <= W'(1);
          aux <= left;
          rem <= right;
          if (right[W-1]) begin
            pow_exact <= 1'b1;
            if (left == W'(1)) result <= W'(1);
            else if (left == '1) result <= right[0] ? '1 : W'(1);
            else begin
              result <= '0;
              div_zero <= (left == '0);
            end
          end
        end
      endcase
    end else if (cmd.iter) begin
      cnt <= cnt - IW'(1);
      if (op == OP_DIV) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          acc <= {acc[W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          acc <= {acc[W-2:0], 1'b0};
        end
        if (cnt == IW'(1))
          result <= div_zero ? '0 : (neg_q ? neg(trial[W] ? {acc[W-2:0], 1'b0}
            : {acc[W-2:0], 1'b1}) : (trial[W] ? {acc[W-2:0], 1'b0} : {acc[W-2:0], 1'b1}));
      end else begin
        if (rem[0]) acc <= prod_a[W-1:0];
        aux <= prod_s[W-1:0];
        rem <= rem >> 1;
        if (cnt == IW'(1)) result <= rem[0] ? prod_a[W-1:0] : acc;
      end
    end
  end

  always_comb begin
    stat.is_digit = is_digit;
    stat.is_op = is_op;
    stat.is_last = last;
    stat.full = (count == CW'(STACK_DEPTH));
    stat.lt2 = (count < CW'(2));
    stat.iter_done = (cnt == IW'(1));
    stat.multi = (op == OP_DIV) || ((op == OP_POW) && !pow_exact);
  end
endmodule

>>> hdl/ppse_ctrl.sv
// Controller state machine for the stack evaluator.
// Depends on ppse_pkg and the assertion macros.
`include "postfix_prefix_stack_evaluator_macros.svh"
module ppse_ctrl import ppse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (stat.is_op && !stat.lt2) state_next = S_READ1;
        else state_next = S_EXEC;
      end
      S_READ1: state_next = S_READ2;
      S_READ2: state_next = S_EXEC;
      S_EXEC: begin
        if (stat.is_op && !stat.lt2) state_next = S_ITER;
        else state_next = S_FINISH;
      end
      S_ITER: if (!stat.multi || stat.iter_done) state_next = S_WRITE;
      S_WRITE: state_next = S_FINISH;
      S_FINISH: state_next = stat.is_last ? S_OUT : S_IDLE;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state == S_IDLE);
    out_valid = (state == S_OUT);
    case (state)
      S_IDLE: cmd.load = in_valid;
      S_DECODE: begin
        cmd.push = stat.is_digit;
        cmd.rd_top = 1'b0;
      end
      S_READ1: cmd.rd_top = 1'b1;
      S_READ2: cmd.rd_below = 1'b1;
      S_EXEC: cmd.exec = 1'b1;
      S_ITER: cmd.iter = stat.multi;
      S_WRITE: cmd.wr_res = 1'b1;
      S_FINISH: begin
        cmd.rd_last = 1'b1;
        cmd.finish = stat.is_last;
      end
      S_OUT: cmd.out_take = out_ready;
      default: ;
    endcase
  end

  `PPSE_ASSERT_IMPL(a_excl, clk, rst, 1'b1, !(in_ready && out_valid))
  `PPSE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `PPSE_ASSERT_NEXT(a_write_fin, clk, rst, cmd.wr_res, state == S_FINISH)
endmodule

>>> dv/tb.sv
// Testbench for postfix_prefix_stack_evaluator: random and directed symbol streams,
// a scoreboard class holding the operand-stack predictor. Depends on ppse_pkg and ppse_if.
module tb;
  import ppse_pkg::*;

  localparam int DEPTH = 32;
  localparam int W = 16;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [15:0] value;
    status_t     status;
  } expr_result_t;

  class eval_scoreboard;
    logic [W-1:0]  stk[DEPTH];
    int            cnt;
    status_t       err;
    bit            prefix;
    expr_result_t  pending[$];
    int            mismatches;

    function new();
      cnt = 0;
      err = ST_OK;
      prefix = 0;
      mismatches = 0;
    endfunction

    function void flag(status_t s);
      if (err == ST_OK) err = s;
    endfunction

    function logic [W-1:0] divide(logic [W-1:0] a, logic [W-1:0] b);
      logic [W-1:0] ma, mb, q;
      if (b == 0) begin
        flag(ST_MATH);
        return 0;
      end
      ma = a[W-1] ? -a : a;
      mb = b[W-1] ? -b : b;
      q = ma / mb;
      return (a[W-1] != b[W-1]) ? -q : q;
    endfunction

    function logic [W-1:0] power(logic [W-1:0] base, logic [W-1:0] ex);
      logic [W-1:0] acc, sq;
      if (ex[W-1]) begin
        if (base == 1) return 1;
        if (base == {W{1'b1}}) return ex[0] ? {W{1'b1}} : 1;
        if (base == 0) flag(ST_MATH);
        return 0;
      end
      acc = 1;
      sq = base;
      while (ex != 0) begin
        if (ex[0]) acc = acc * sq;
        sq = sq * sq;
        ex = ex >> 1;
      end
      return acc;
    endfunction

    function void note_symbol(logic [7:0] sym, logic last);
      logic [W-1:0] l, r, res;
      expr_result_t e;
      if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
        if (cnt >= DEPTH) flag(ST_OVERFLOW);
        else begin
          stk[cnt] = W'(sym - SYM_ZERO);
          cnt++;
        end
      end else if (sym == SYM_PLUS || sym == SYM_MINUS || sym == SYM_MUL ||
                   sym == SYM_DIV || sym == SYM_DOLR || sym == SYM_CARET) begin
        if (cnt < 2) flag(ST_UNDERFLOW);
        else begin
          l = prefix ? stk[cnt-1] : stk[cnt-2];
          r = prefix ? stk[cnt-2] : stk[cnt-1];
          case (sym)
            SYM_PLUS:  res = l + r;
            SYM_MINUS: res = l - r;
            SYM_MUL:   res = l * r;
            SYM_DIV:   res = divide(l, r);
            default:   res = power(l, r);
          endcase
          cnt--;
          stk[cnt-1] = res;
        end
      end else flag(ST_BADSYM);
      if (last) begin
        e.value = 0;
        if (cnt == 0) flag(ST_UNDERFLOW);
        else e.value = stk[cnt-1];
        e.status = err;
        pending.push_back(e);
        cnt = 0;
        err = ST_OK;
      end
    endfunction

    function void check_result(logic [15:0] value, logic [2:0] status);
      expr_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result value=%0d status=%0d", $signed(value), status);
        return;
      end
      e = pending.pop_front();
      if (value !== e.value || status !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp value=%0d status=%0d, got value=%0d status=%0d",
                   $signed(e.value), e.status, $signed(value), status);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  ppse_in_if  in_ch();
  ppse_out_if out_ch();
  ppse_cfg_if cfg();

  postfix_prefix_stack_evaluator #(.STACK_DEPTH(DEPTH), .VALUE_WIDTH(W)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
  );

  eval_scoreboard sb;
  bit quiet;
  int idle_cnt;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.symbol = 0;
    in_ch.last = 0;
    out_ch.ready = 0;
    cfg.valid = 0;
    cfg.data = 0;
    rst = 1;
  end

  // result sink with random stall bursts
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 0;
        n = $urandom_range(1, 10);
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.value, out_ch.status);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready))
      idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("postfix_prefix_stack_evaluator test failed");
      $finish;
    end
  end

  task automatic send_symbol(input logic [7:0] sym, input logic last);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 0;
      n = $urandom_range(1, 10);
      repeat (n) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.symbol <= sym;
    in_ch.last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_symbol(sym, last);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    drain();
    cfg.valid <= 1;
    cfg.data <= m;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
    sb.prefix = m;
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 5))
      0: return SYM_PLUS;
      1: return SYM_MINUS;
      2: return SYM_MUL;
      3: return SYM_DIV;
      4: return SYM_DOLR;
      default: return SYM_CARET;
    endcase
  endfunction

  function automatic logic [7:0] rand_digit();
    return SYM_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // well-formed expression: depth tracked so the stack never underflows
  task automatic send_expr(input int ops);
    int d;
    d = 0;
    while (ops > 0 || d != 1) begin
      if (d >= 2 && (ops == 0 || $urandom_range(0, 1) == 0) && d + ops > 1) begin
        send_symbol(rand_op(), (ops == 0 && d == 2));
        d--;
        if (ops > 0) ops--;
      end else begin
        send_symbol(rand_digit(), 0);
        d++;
      end
      if (d == 1 && ops == 0) break;
      if (d == 1 && ops > 0) ops = ops;
    end
    if (d == 1 && sb.cnt != 0 && !in_ch.last) send_symbol(SYM_PLUS, 1);
  endtask

  task automatic send_noise(input int len);
    logic [7:0] s;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 3))
        0: s = 8'($urandom_range(0, 255));
        1: s = rand_op();
        default: s = rand_digit();
      endcase
      send_symbol(s, i == len - 1);
    end
  endtask

  initial begin
    int items;
    sb = new();
    quiet = 0;
    idle_cnt = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: every operator, edge values, error cases
    send_symbol("9", 0); send_symbol("7", 0); send_symbol(SYM_PLUS, 1);
    send_symbol("3", 0); send_symbol("8", 0); send_symbol(SYM_MINUS, 1);
    send_symbol("9", 0); send_symbol("9", 0); send_symbol(SYM_MUL, 1);
    send_symbol("0", 0); send_symbol("7", 0); send_symbol(SYM_MINUS, 0);
    send_symbol("2", 0); send_symbol(SYM_DIV, 1);
    send_symbol("5", 0); send_symbol("0", 0); send_symbol(SYM_DIV, 1);
    send_symbol("9", 0); send_symbol("9", 0); send_symbol(SYM_CARET, 1);
    send_symbol("0", 0); send_symbol("0", 0); send_symbol(SYM_DOLR, 1);
    send_symbol(SYM_PLUS, 1);
    send_symbol(8'hFF, 1);
    send_symbol(8'h00, 0); send_symbol("4", 1);
    for (int i = 0; i < 33; i++) send_symbol("1", i == 32);
    // most negative / -1, and negative exponents
    send_symbol("0", 0); send_symbol("8", 0); send_symbol(SYM_MINUS, 0);
    send_symbol("8", 0); send_symbol("8", 0); send_symbol(SYM_MUL, 0);
    send_symbol("8", 0); send_symbol(SYM_MUL, 0); send_symbol("8", 0);
    send_symbol(SYM_MUL, 0); send_symbol("8", 0); send_symbol(SYM_MUL, 0);
    send_symbol("0", 0); send_symbol("1", 0); send_symbol(SYM_MINUS, 0);
    send_symbol(SYM_DIV, 1);
    for (int b = 0; b < 4; b++) begin
      send_symbol("0", 0); send_symbol("1", 0); send_symbol(SYM_MINUS, 0);
      if (b == 3) send_symbol("0", 0);
      else send_symbol(8'(SYM_ZERO + b), 0);
      send_symbol("0", 0); send_symbol("3", 0); send_symbol(SYM_MINUS, 0);
      send_symbol(SYM_CARET, 1);
    end
    write_mode(1);
    send_symbol("2", 0); send_symbol("9", 0); send_symbol(SYM_MINUS, 1);
    send_symbol("3", 0); send_symbol("8", 0); send_symbol(SYM_DIV, 1);
    write_mode(0);

    items = 0;
    for (int phase = 0; phase < 4; phase++) begin
      if (phase > 0) write_mode(phase[0]);
      if (phase == 3) quiet = 1;
      while (items < (phase + 1) * 250) begin
        if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 12));
        else send_expr($urandom_range(0, 10));
        items = items + 10;
      end
    end

    in_ch.valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("postfix_prefix_stack_evaluator test passed");
    else
      $display("postfix_prefix_stack_evaluator test failed");
    $finish;
  end
endmodule
